[rtl/core/cra_pkg.sv]
// Package for the color ramp by age unit.
// Holds shared constants, register indexes and the pipeline transaction structs.
// No dependencies.
package cra_pkg;

    localparam int MAX_STOPS_DEF = 6;

    // Fixed-point 1.0 in UQ1.16.
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    localparam int FIELD_W      = 16;
    localparam int COLOR_W      = 32;
    localparam int CHAN_W       = 8;
    localparam int COUNT_W      = 3;
    localparam int CFG_INDEX_W  = 3;
    localparam int STOP_IDX_W   = 3;

    // Restoring divider: quotient bits resolved per stage and number of stages.
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES         = FIELD_W / DIV_BITS_PER_STAGE;

    localparam logic [CFG_INDEX_W-1:0] REG_STOP_COUNT   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STOP_COLOR_0 = 3'd1;

    typedef struct packed {
        logic               valid;
        logic               sat;
        logic [FIELD_W-1:0] life;
        logic [FIELD_W-1:0] rem;
        logic [FIELD_W-1:0] quot;
    } cra_div_t;

    typedef struct packed {
        logic                  valid;
        logic [STOP_IDX_W-1:0] idx;
        logic [STOP_IDX_W-1:0] nxt;
        logic [FIELD_W-1:0]    frac;
    } cra_pos_t;

endpackage

[rtl/core/cra_ram.sv]
// Generic RAM with one write port and two registered read ports.
// Depends on nothing.
module cra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 6,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [WIDTH-1:0]  rdata_a,
    output logic [WIDTH-1:0]  rdata_b
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a_reg <= mem_reg[raddr_a];
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;
endmodule

[rtl/core/cra_div_stage.sv]
// One stage of the pipelined restoring divider for the life ratio.
// Depends on cra_pkg.
module cra_div_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  cra_pkg::cra_div_t d_in,
    output cra_pkg::cra_div_t d_out
);
    import cra_pkg::*;

    logic               valid_reg;
    logic               sat_reg;
    logic [FIELD_W-1:0] life_reg;
    logic [FIELD_W-1:0] rem_reg;
    logic [FIELD_W-1:0] quot_reg;
    logic [FIELD_W-1:0] rem_next;
    logic [FIELD_W-1:0] quot_next;

    // The remainder stays below the divisor, so the shifted value fits in 17 bits.
    always_comb
    begin
        logic [FIELD_W:0] shifted;
        rem_next  = d_in.rem;
        quot_next = d_in.quot;
        for (int i = 0; i < DIV_BITS_PER_STAGE; i++)
        begin
            shifted = {rem_next, 1'b0};
            if (shifted >= {1'b0, d_in.life})
            begin
                shifted   = shifted - {1'b0, d_in.life};
                quot_next = {quot_next[FIELD_W-2:0], 1'b1};
            end
            else
            begin
                quot_next = {quot_next[FIELD_W-2:0], 1'b0};
            end
            rem_next = shifted[FIELD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= d_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sat_reg  <= d_in.sat;
            life_reg <= d_in.life;
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    always_comb
    begin
        d_out.valid = valid_reg;
        d_out.sat   = sat_reg;
        d_out.life  = life_reg;
        d_out.rem   = rem_reg;
        d_out.quot  = quot_reg;
    end
endmodule

[rtl/core/cra_scale.sv]
// Scales the life ratio by the stop span and splits it into stop index and fraction.
// Depends on cra_pkg.
module cra_scale (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic [cra_pkg::STOP_IDX_W-1:0]   last_idx,
    input  cra_pkg::cra_div_t                d_in,
    output cra_pkg::cra_pos_t                p_out
);
    import cra_pkg::*;

    localparam int SCALED_W = 17 + STOP_IDX_W;

    logic                  valid_reg;
    logic [STOP_IDX_W-1:0] idx_reg;
    logic [STOP_IDX_W-1:0] nxt_reg;
    logic [FIELD_W-1:0]    frac_reg;
    logic [STOP_IDX_W-1:0] idx_next;
    logic [STOP_IDX_W-1:0] nxt_next;
    logic [FIELD_W-1:0]    frac_next;
    logic [16:0]           ratio;
    logic [SCALED_W-1:0]   scaled;
    logic [SCALED_W-17:0]  whole;

    always_comb
    begin
        ratio  = d_in.sat ? ONE_Q16 : {1'b0, d_in.quot};
        scaled = SCALED_W'(ratio) * SCALED_W'(last_idx);
        whole  = scaled[SCALED_W-1:16];
        // At or past the last stop the ramp holds the last color.
        if (whole >= {1'b0, last_idx})
        begin
            idx_next  = last_idx;
            frac_next = '0;
        end
        else
        begin
            idx_next  = whole[STOP_IDX_W-1:0];
            frac_next = scaled[15:0];
        end
        nxt_next = (idx_next < last_idx) ? idx_next + 1'b1 : idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= d_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            idx_reg  <= idx_next;
            nxt_reg  <= nxt_next;
            frac_reg <= frac_next;
        end
    end

    always_comb
    begin
        p_out.valid = valid_reg;
        p_out.idx   = idx_reg;
        p_out.nxt   = nxt_reg;
        p_out.frac  = frac_reg;
    end
endmodule

[rtl/core/cra_blend.sv]
// Two-stage per-channel linear blend of two RGBA stop colors.
// Depends on cra_pkg.
module cra_blend (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_vld,
    input  logic [cra_pkg::FIELD_W-1:0]   frac,
    input  logic [cra_pkg::COLOR_W-1:0]   color_a,
    input  logic [cra_pkg::COLOR_W-1:0]   color_b,
    output logic                          res_vld,
    output logic [cra_pkg::COLOR_W-1:0]   color
);
    import cra_pkg::*;

    localparam int NCH    = COLOR_W / CHAN_W;
    localparam int PROD_W = CHAN_W + 17;

    logic              mul_valid_reg;
    logic              out_valid_reg;
    logic [PROD_W-1:0] prod_a_reg [NCH];
    logic [PROD_W-1:0] prod_b_reg [NCH];
    logic [PROD_W-1:0] prod_a_next [NCH];
    logic [PROD_W-1:0] prod_b_next [NCH];
    logic [COLOR_W-1:0] color_reg;
    logic [COLOR_W-1:0] color_next;
    logic [16:0]       weight_a;

    always_comb
    begin
        logic [PROD_W-1:0] sum;
        weight_a = ONE_Q16 - {1'b0, frac};
        for (int c = 0; c < NCH; c++)
        begin
            prod_a_next[c] = PROD_W'(color_a[c*CHAN_W +: CHAN_W]) * PROD_W'(weight_a);
            prod_b_next[c] = PROD_W'(color_b[c*CHAN_W +: CHAN_W]) * PROD_W'(frac);
        end
        for (int c = 0; c < NCH; c++)
        begin
            sum = prod_a_reg[c] + prod_b_reg[c];
            color_next[c*CHAN_W +: CHAN_W] = sum[16 +: CHAN_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            mul_valid_reg <= in_vld;
            out_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
            color_reg  <= color_next;
        end
    end

    assign res_vld = out_valid_reg;
    assign color   = color_reg;
endmodule

[rtl/core/color_ramp_by_age_unit.sv]
// Color ramp by age: maps a particle's age and lifetime to an RGBA gradient color.
// Depends on cra_pkg, cra_ram, cra_div_stage, cra_scale and cra_blend.
//
// Input channel: in_valid/in_ready with particle_age and particle_lifetime.
// Output channel: out_valid/out_ready with red, green, blue and alpha.
// Configuration: cfg_write, cfg_index and cfg_data; index 0 is the stop count,
// indexes 1 to 6 the stop colors. Writes take effect on the clock edge and must
// happen while no transaction is in flight.
// Eight divider stages resolve two quotient bits each, then come ratio scaling,
// stop color read, channel multiply and the output register; the divider sets
// the depth. Throughput is one transaction per cycle unless the output stalls.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_ready drops in the same cycle, even if the earlier stages hold only
// bubbles.
// Reset empties the pipeline, sets the stop count to one and all stop colors to
// zero. No clearing pass is needed after reset.
module color_ramp_by_age_unit #(
    parameter int MAX_STOPS = cra_pkg::MAX_STOPS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [cra_pkg::FIELD_W-1:0]        particle_age,
    input  logic [cra_pkg::FIELD_W-1:0]        particle_lifetime,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [cra_pkg::CHAN_W-1:0]         red,
    output logic [cra_pkg::CHAN_W-1:0]         green,
    output logic [cra_pkg::CHAN_W-1:0]         blue,
    output logic [cra_pkg::CHAN_W-1:0]         alpha,
    input  logic                               cfg_write,
    input  logic [cra_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cra_pkg::COLOR_W-1:0]        cfg_data
);
    import cra_pkg::*;

    localparam int ADDR_W = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
    localparam logic [COUNT_W-1:0] MAX_N = COUNT_W'(MAX_STOPS);

    logic                   en;
    logic [COUNT_W-1:0]     stop_count_reg;
    logic [COUNT_W-1:0]     n_used;
    logic [STOP_IDX_W-1:0]  last_idx;
    logic [MAX_STOPS-1:0]   col_vld_reg;
    logic [CFG_INDEX_W-1:0] color_off;
    logic                   color_we;
    cra_div_t               div_pipe [DIV_STAGES+1];
    cra_pos_t               pos;
    logic                   sel_valid_reg;
    logic [FIELD_W-1:0]     sel_frac_reg;
    logic                   sel_ok_a_reg;
    logic                   sel_ok_b_reg;
    logic [COLOR_W-1:0]     ram_a;
    logic [COLOR_W-1:0]     ram_b;
    logic [COLOR_W-1:0]     color_a;
    logic [COLOR_W-1:0]     color_b;
    logic [COLOR_W-1:0]     color;
    logic                   res_vld;

    // The pipeline moves as one whenever the output register can take a result.
    assign en       = !res_vld || out_ready;
    assign in_ready = en;

    // Configuration registers.
    assign color_off = cfg_index - REG_STOP_COLOR_0;
    assign color_we  = cfg_write && (cfg_index >= REG_STOP_COLOR_0)
                       && ({1'b0, color_off} < (CFG_INDEX_W + 1)'(MAX_STOPS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_count_reg <= COUNT_W'(1);
            col_vld_reg    <= '0;
        end
        else
        begin
            if (cfg_write && (cfg_index == REG_STOP_COUNT))
            begin
                stop_count_reg <= cfg_data[COUNT_W-1:0];
            end
            if (color_we)
            begin
                col_vld_reg[color_off[ADDR_W-1:0]] <= 1'b1;
            end
        end
    end

    always_comb
    begin
        if (stop_count_reg == '0)
        begin
            n_used = COUNT_W'(1);
        end
        else if (stop_count_reg > MAX_N)
        begin
            n_used = MAX_N;
        end
        else
        begin
            n_used = stop_count_reg;
        end
        last_idx = n_used - 1'b1;
    end

    // Divider entry: a zero lifetime or an age at or past it saturates the ratio.
    always_comb
    begin
        div_pipe[0].valid = in_valid;
        div_pipe[0].sat   = (particle_lifetime == '0) || (particle_age >= particle_lifetime);
        div_pipe[0].life  = particle_lifetime;
        div_pipe[0].rem   = particle_age;
        div_pipe[0].quot  = '0;
    end

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_div
        cra_div_stage u_div (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .d_in  (div_pipe[s]),
            .d_out (div_pipe[s+1])
        );
    end

    cra_scale u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .last_idx (last_idx),
        .d_in     (div_pipe[DIV_STAGES]),
        .p_out    (pos)
    );

    cra_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (MAX_STOPS)
    ) u_stops (
        .clk     (clk),
        .we      (color_we),
        .waddr   (color_off[ADDR_W-1:0]),
        .wdata   (cfg_data),
        .re      (en),
        .raddr_a (pos.idx[ADDR_W-1:0]),
        .raddr_b (pos.nxt[ADDR_W-1:0]),
        .rdata_a (ram_a),
        .rdata_b (ram_b)
    );

    // Stop color read stage; a stop never written reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sel_valid_reg <= pos.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sel_frac_reg <= pos.frac;
            sel_ok_a_reg <= col_vld_reg[pos.idx[ADDR_W-1:0]];
            sel_ok_b_reg <= col_vld_reg[pos.nxt[ADDR_W-1:0]];
        end
    end

    assign color_a = sel_ok_a_reg ? ram_a : '0;
    assign color_b = sel_ok_b_reg ? ram_b : '0;

    cra_blend u_blend (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (sel_valid_reg),
        .frac    (sel_frac_reg),
        .color_a (color_a),
        .color_b (color_b),
        .res_vld (res_vld),
        .color   (color)
    );

    assign out_valid = res_vld;
    assign red       = color[31:24];
    assign green     = color[23:16];
    assign blue      = color[15:8];
    assign alpha     = color[7:0];

`ifndef ASSERT_OFF
    a_zero_life_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (particle_lifetime == '0)) |=> div_pipe[1].sat)
        else $error("zero lifetime did not saturate the ratio");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos.valid |-> (pos.idx <= last_idx) && (pos.nxt <= last_idx))
        else $error("stop index beyond the last stop in use");

    a_last_stop_no_blend: assert property (@(posedge clk) disable iff (!rst_n)
        (pos.valid && (pos.idx == last_idx)) |-> (pos.frac == '0))
        else $error("blend fraction set at the last stop");

    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (!en) |=> $stable(sel_valid_reg) && $stable(pos.valid))
        else $error("pipeline moved during an output stall");
`endif
endmodule
